// File: src/lsda_pkg.sv
// ----------------------------------------------------------------------------
// lsda_pkg
// Types and codes shared by the link-state database aging block.
// ----------------------------------------------------------------------------
package lsda_pkg;

   localparam logic [1:0] MODE_ADVERT = 2'd0;
   localparam logic [1:0] MODE_DELETE = 2'd1;
   localparam logic [1:0] MODE_TICK   = 2'd2;
   localparam logic [1:0] MODE_SWEEP  = 2'd3;

   localparam logic [3:0] ST_INSERTED   = 4'd0;
   localparam logic [3:0] ST_REFRESHED  = 4'd1;
   localparam logic [3:0] ST_STALE      = 4'd2;
   localparam logic [3:0] ST_FULL       = 4'd3;
   localparam logic [3:0] ST_DELETED    = 4'd4;
   localparam logic [3:0] ST_ABSENT     = 4'd5;
   localparam logic [3:0] ST_ADVERT     = 4'd6;
   localparam logic [3:0] ST_SWEEP_DONE = 4'd7;
   localparam logic [3:0] ST_TICK       = 4'd8;

   localparam logic [7:0] CSR_OWN_ADDRESS = 8'd0;
   localparam logic [7:0] CSR_LINK_TIMEOUT = 8'd1;

   localparam logic [15:0] TIMEOUT_RESET = 16'd120;

   typedef struct packed {
      logic [1:0]  mode;
      logic [63:0] link_source;
      logic [63:0] link_dest;
      logic [63:0] link_sequence;
   } req_item_type;

   typedef struct packed {
      logic [3:0]  status;
      logic [63:0] adv_source;
      logic [63:0] adv_dest;
      logic [63:0] adv_sequence;
      logic        last;
   } rsp_item_type;

   typedef struct packed {
      logic [63:0] source;
      logic [63:0] dest;
      logic [63:0] seqno;
      logic [31:0] stamp;
   } entry_type;

endpackage

// File: src/lsda_fifo.sv
// ----------------------------------------------------------------------------
// lsda_fifo
// Small register queue, used between the ports and the table engine.
// ----------------------------------------------------------------------------
module lsda_fifo #(
   parameter type item_type = logic,
   parameter int DEPTH = 2
) (
   input  logic     clock,
   input  logic     reset,
   input  logic     push,
   input  item_type push_data,
   output logic     full,
   input  logic     pop,
   output item_type pop_data,
   output logic     empty
);
   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   item_type          store_ff [DEPTH];
   logic [PW-1:0]     wp_ff, rp_ff;
   logic [CW-1:0]     cnt_ff;
   logic              do_push, do_pop;

   assign full     = (cnt_ff == CW'(DEPTH));
   assign empty    = (cnt_ff == '0);
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign pop_data = store_ff[rp_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff  <= '0;
         rp_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         if (do_push) begin
            store_ff[wp_ff] <= push_data;
            wp_ff <= (wp_ff == PW'(DEPTH - 1)) ? '0 : PW'(wp_ff + 1'b1);
         end
         if (do_pop) begin
            rp_ff <= (rp_ff == PW'(DEPTH - 1)) ? '0 : PW'(rp_ff + 1'b1);
         end
         cnt_ff <= CW'(cnt_ff + CW'(do_push) - CW'(do_pop));
      end
   end
endmodule

// File: src/lsda_engine.sv
// ----------------------------------------------------------------------------
// lsda_engine
// Table engine: walks the sorted link table entry by entry, with a read state and an examine state per entry.
// ----------------------------------------------------------------------------
module lsda_engine import lsda_pkg::*; #(
   parameter int TABLE_DEPTH = 32
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         cmd_empty,
   input  req_item_type cmd_item,
   output logic         cmd_pop,
   input  logic         out_full,
   output logic         out_push,
   output rsp_item_type out_item,
   input  logic         csr_valid,
   input  logic [7:0]   csr_index,
   input  logic [63:0]  csr_wdata
);
   localparam int AW = $clog2(TABLE_DEPTH);
   localparam int CW = $clog2(TABLE_DEPTH + 1);

   typedef enum logic [3:0] {
      IDLE, SCAN_RD, SCAN_EX, INS_RD, INS_EX, DEL_RD, DEL_EX, SWP_RD, SWP_EX, FINISH
   } state_type;

   state_type     state_ff;
   req_item_type  cmd_ff;
   entry_type     table_ff [TABLE_DEPTH];
   entry_type     rd_data_ff, carry_ff;
   rsp_item_type  result_ff;
   logic          pend_ff;
   logic [CW-1:0] idx_ff, wr_ff, count_ff, pos_ff, found_idx_ff;
   logic          found_ff, pos_set_ff;
   logic [63:0]   fseq_ff, own_ff;
   logic [15:0]   timeout_ff;
   logic [31:0]   seconds_ff;
   logic [AW-1:0] rd_addr;
   logic [CW-1:0] idx_inc;
   logic          key_eq, key_gt;
   logic [31:0]   age;
   entry_type     adv_entry;

   assign idx_inc = CW'(idx_ff + 1'b1);
   assign rd_addr = (state_ff == DEL_RD) ? idx_inc[AW-1:0] : idx_ff[AW-1:0];
   assign key_eq  = (rd_data_ff.dest == cmd_ff.link_dest) &&
                    (rd_data_ff.source == cmd_ff.link_source);
   // entry sorts at or after the key, so the new link goes here
   assign key_gt  = !((rd_data_ff.dest < cmd_ff.link_dest) ||
                      ((rd_data_ff.dest == cmd_ff.link_dest) &&
                       (rd_data_ff.source < cmd_ff.link_source)));
   assign age     = seconds_ff - rd_data_ff.stamp;
   assign adv_entry = '{source: rd_data_ff.source, dest: rd_data_ff.dest,
                        seqno: rd_data_ff.seqno + 64'd1, stamp: seconds_ff};

   assign cmd_pop  = (state_ff == IDLE) && !cmd_empty;
   assign out_item = result_ff;
   assign out_push = !out_full &&
                     ((state_ff == FINISH) ||
                      ((state_ff == SWP_EX) && pend_ff && (age <= {16'd0, timeout_ff}) &&
                       (rd_data_ff.source == own_ff)));

   always_ff @(posedge clock) begin
      rd_data_ff <= table_ff[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= IDLE;
         count_ff   <= '0;
         seconds_ff <= '0;
         own_ff     <= '0;
         timeout_ff <= TIMEOUT_RESET;
         pend_ff    <= 1'b0;
      end else begin
         if (csr_valid && csr_index == CSR_OWN_ADDRESS) own_ff <= csr_wdata;
         if (csr_valid && csr_index == CSR_LINK_TIMEOUT) timeout_ff <= csr_wdata[15:0];
         unique case (state_ff)
            IDLE: begin
               if (!cmd_empty) begin
                  cmd_ff     <= cmd_item;
                  idx_ff     <= '0;
                  wr_ff      <= '0;
                  found_ff   <= 1'b0;
                  pos_set_ff <= 1'b0;
                  pend_ff    <= 1'b0;
                  unique case (cmd_item.mode)
                     MODE_TICK: begin
                        seconds_ff <= seconds_ff + 32'd1;
                        result_ff  <= '{status: ST_TICK, last: 1'b1, default: '0};
                        state_ff   <= FINISH;
                     end
                     MODE_SWEEP: state_ff <= SWP_RD;
                     default:    state_ff <= SCAN_RD;
                  endcase
               end
            end
            SCAN_RD: begin
               if (idx_ff == count_ff) begin
                  if (cmd_ff.mode == MODE_DELETE) begin
                     if (found_ff) begin
                        idx_ff   <= found_idx_ff;
                        state_ff <= DEL_RD;
                     end else begin
                        result_ff <= '{status: ST_ABSENT, last: 1'b1, default: '0};
                        state_ff  <= FINISH;
                     end
                  end else if (found_ff) begin
                     if (fseq_ff < cmd_ff.link_sequence) begin
                        table_ff[found_idx_ff[AW-1:0]] <= '{source: cmd_ff.link_source,
                           dest: cmd_ff.link_dest, seqno: cmd_ff.link_sequence,
                           stamp: seconds_ff};
                        result_ff <= '{status: ST_REFRESHED, last: 1'b1, default: '0};
                     end else begin
                        result_ff <= '{status: ST_STALE, last: 1'b1, default: '0};
                     end
                     state_ff <= FINISH;
                  end else if (count_ff == CW'(TABLE_DEPTH)) begin
                     result_ff <= '{status: ST_FULL, last: 1'b1, default: '0};
                     state_ff  <= FINISH;
                  end else begin
                     carry_ff <= '{source: cmd_ff.link_source, dest: cmd_ff.link_dest,
                                   seqno: cmd_ff.link_sequence, stamp: seconds_ff};
                     idx_ff   <= pos_set_ff ? pos_ff : count_ff;
                     state_ff <= INS_RD;
                  end
               end else begin
                  state_ff <= SCAN_EX;
               end
            end
            SCAN_EX: begin
               if (key_eq) begin
                  found_ff     <= 1'b1;
                  found_idx_ff <= idx_ff;
                  fseq_ff      <= rd_data_ff.seqno;
               end
               if (!pos_set_ff && key_gt) begin
                  pos_set_ff <= 1'b1;
                  pos_ff     <= idx_ff;
               end
               idx_ff   <= idx_inc;
               state_ff <= SCAN_RD;
            end
            INS_RD: state_ff <= INS_EX;
            INS_EX: begin
               // carry ripples every later entry up one slot
               table_ff[idx_ff[AW-1:0]] <= carry_ff;
               carry_ff <= rd_data_ff;
               if (idx_ff == count_ff) begin
                  count_ff  <= CW'(count_ff + 1'b1);
                  result_ff <= '{status: ST_INSERTED, last: 1'b1, default: '0};
                  state_ff  <= FINISH;
               end else begin
                  idx_ff   <= idx_inc;
                  state_ff <= INS_RD;
               end
            end
            DEL_RD: begin
               if (idx_inc == count_ff) begin
                  count_ff  <= CW'(count_ff - 1'b1);
                  result_ff <= '{status: ST_DELETED, last: 1'b1, default: '0};
                  state_ff  <= FINISH;
               end else begin
                  state_ff <= DEL_EX;
               end
            end
            DEL_EX: begin
               table_ff[idx_ff[AW-1:0]] <= rd_data_ff;
               idx_ff   <= idx_inc;
               state_ff <= DEL_RD;
            end
            SWP_RD: begin
               if (idx_ff == count_ff) begin
                  count_ff <= wr_ff;
                  if (pend_ff) result_ff.last <= 1'b1;
                  else result_ff <= '{status: ST_SWEEP_DONE, last: 1'b1, default: '0};
                  state_ff <= FINISH;
               end else begin
                  state_ff <= SWP_EX;
               end
            end
            SWP_EX: begin
               if (age > {16'd0, timeout_ff}) begin
                  idx_ff   <= idx_inc;
                  state_ff <= SWP_RD;
               end else if (rd_data_ff.source == own_ff) begin
                  // previous advert goes out once the next one is known
                  if (!pend_ff || !out_full) begin
                     table_ff[wr_ff[AW-1:0]] <= adv_entry;
                     result_ff <= '{status: ST_ADVERT, adv_source: adv_entry.source,
                                    adv_dest: adv_entry.dest,
                                    adv_sequence: adv_entry.seqno, last: 1'b0};
                     pend_ff  <= 1'b1;
                     wr_ff    <= CW'(wr_ff + 1'b1);
                     idx_ff   <= idx_inc;
                     state_ff <= SWP_RD;
                  end
               end else begin
                  table_ff[wr_ff[AW-1:0]] <= rd_data_ff;
                  wr_ff    <= CW'(wr_ff + 1'b1);
                  idx_ff   <= idx_inc;
                  state_ff <= SWP_RD;
               end
            end
            FINISH: begin
               if (!out_full) state_ff <= IDLE;
            end
            default: state_ff <= IDLE;
         endcase
      end
   end

`ifndef ASSERT_OFF
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(TABLE_DEPTH)) else $error("entry count beyond table depth");
   a_no_push_full: assert property (@(posedge clock) disable iff (reset)
      out_push |-> !out_full) else $error("result pushed into full queue");
   a_finish_last: assert property (@(posedge clock) disable iff (reset)
      (state_ff == FINISH) |-> result_ff.last) else $error("final result without last");
   a_wr_behind: assert property (@(posedge clock) disable iff (reset)
      (state_ff == SWP_EX) |-> (wr_ff <= idx_ff)) else $error("sweep write ahead of read");
`endif
endmodule

// File: src/link_state_database_aging_core.sv
// from queue pop to result push: tick goes straight to the finish state; refresh, stale,
// full, absent and sweep walk every entry; insert walks every entry, then moves each
// later entry up; delete walks every entry, then moves each later entry down.
// one item at a time: the single-port table walk finishes each item before the next
// is popped. results pass through a 4-deep queue, inputs a 2-deep queue.
// reset: synchronous, clears table count, clock, queues; timeout returns to 120.
// ----------------------------------------------------------------------------
// link_state_database_aging_core
// Sorted link-state table with insert, refresh, delete and aging sweep.
// ----------------------------------------------------------------------------
module link_state_database_aging_core import lsda_pkg::*; #(
   parameter int TABLE_DEPTH = 32
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_push,
   input  req_item_type req_data,
   output logic         full,
   output logic         req_full,
   output logic         empty,
   output logic         rsp_empty,
   input  logic         rsp_pop,
   output rsp_item_type rsp_data,
   input  logic         csr_valid,
   output logic         csr_ready,
   input  logic [7:0]   csr_index,
   input  logic [63:0]  csr_wdata
);
   logic         cmd_empty, cmd_pop, out_full, out_push;
   req_item_type cmd_item;
   rsp_item_type out_item;

   assign csr_ready = 1'b1;
   assign full      = req_full;
   assign empty     = rsp_empty;

   lsda_fifo #(.item_type(req_item_type), .DEPTH(2)) u_cmd_q (
      .clock, .reset,
      .push(req_push), .push_data(req_data), .full(req_full),
      .pop(cmd_pop), .pop_data(cmd_item), .empty(cmd_empty)
   );

   lsda_engine #(.TABLE_DEPTH(TABLE_DEPTH)) u_engine (
      .clock, .reset,
      .cmd_empty, .cmd_item, .cmd_pop,
      .out_full, .out_push, .out_item,
      .csr_valid, .csr_index, .csr_wdata
   );

   lsda_fifo #(.item_type(rsp_item_type), .DEPTH(4)) u_rsp_q (
      .clock, .reset,
      .push(out_push), .push_data(out_item), .full(out_full),
      .pop(rsp_pop), .pop_data(rsp_data), .empty(rsp_empty)
   );
endmodule

// File: test/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives advertisements, deletes, ticks and sweeps into the link-state
// database core under several register settings, with random idling on both
// queues, and checks every result against a scoreboard that models the table.
// ----------------------------------------------------------------------------
module testbench;
   import lsda_pkg::*;

   localparam int DEPTH = 32;

   class lsdb_scoreboard;
      logic [63:0]  own_addr;
      logic [15:0]  max_age;
      entry_type    links[DEPTH];
      int unsigned  link_count;
      logic [31:0]  seconds;
      rsp_item_type expected_results[$];
      int           errors;

      function new();
         own_addr   = '0;
         max_age    = TIMEOUT_RESET;
         link_count = 0;
         seconds    = '0;
         errors     = 0;
      endfunction

      function void write_register(logic [7:0] idx, logic [63:0] value);
         if (idx == CSR_OWN_ADDRESS) own_addr = value;
         else if (idx == CSR_LINK_TIMEOUT) max_age = value[15:0];
      endfunction

      function void add_result(logic [3:0] st, logic [63:0] s, logic [63:0] d,
                               logic [63:0] q, logic lst);
         rsp_item_type r;
         r.status       = st;
         r.adv_source   = s;
         r.adv_dest     = d;
         r.adv_sequence = q;
         r.last         = lst;
         expected_results.push_back(r);
      endfunction

      function int find_link(logic [63:0] s, logic [63:0] d);
         for (int i = 0; i < link_count; i++)
            if (links[i].dest == d && links[i].source == s) return i;
         return -1;
      endfunction

      function void drop_link(int idx);
         for (int i = idx; i + 1 < link_count; i++) links[i] = links[i + 1];
         link_count--;
      endfunction

      function void note_request(req_item_type r);
         int pos;
         int n;
         int i;
         logic [31:0] age;
         case (r.mode)
            MODE_ADVERT: begin
               pos = find_link(r.link_source, r.link_dest);
               if (pos >= 0) begin
                  if (links[pos].seqno < r.link_sequence) begin
                     links[pos].seqno = r.link_sequence;
                     links[pos].stamp = seconds;
                     add_result(ST_REFRESHED, '0, '0, '0, 1'b1);
                  end else begin
                     add_result(ST_STALE, '0, '0, '0, 1'b1);
                  end
               end else if (link_count >= DEPTH) begin
                  add_result(ST_FULL, '0, '0, '0, 1'b1);
               end else begin
                  pos = 0;
                  while (pos < link_count && (links[pos].dest < r.link_dest ||
                         (links[pos].dest == r.link_dest &&
                          links[pos].source < r.link_source)))
                     pos++;
                  for (i = link_count; i > pos; i--) links[i] = links[i - 1];
                  links[pos] = '{r.link_source, r.link_dest, r.link_sequence, seconds};
                  link_count++;
                  add_result(ST_INSERTED, '0, '0, '0, 1'b1);
               end
            end
            MODE_DELETE: begin
               pos = find_link(r.link_source, r.link_dest);
               if (pos >= 0) begin
                  drop_link(pos);
                  add_result(ST_DELETED, '0, '0, '0, 1'b1);
               end else begin
                  add_result(ST_ABSENT, '0, '0, '0, 1'b1);
               end
            end
            MODE_TICK: begin
               seconds = seconds + 32'd1;
               add_result(ST_TICK, '0, '0, '0, 1'b1);
            end
            default: begin
               n = 0;
               i = 0;
               while (i < link_count) begin
                  age = seconds - links[i].stamp;
                  if (age > {16'd0, max_age}) begin
                     drop_link(i);
                     continue;
                  end
                  if (links[i].source == own_addr) begin
                     links[i].seqno = links[i].seqno + 64'd1;
                     links[i].stamp = seconds;
                     add_result(ST_ADVERT, links[i].source, links[i].dest,
                                links[i].seqno, 1'b0);
                     n++;
                  end
                  i++;
               end
               if (n == 0) add_result(ST_SWEEP_DONE, '0, '0, '0, 1'b1);
               else expected_results[expected_results.size() - 1].last = 1'b1;
            end
         endcase
      endfunction

      function void check_result(rsp_item_type got);
         rsp_item_type exp_r;
         if (expected_results.size() == 0) begin
            $error("result with nothing expected: status %0d", got.status);
            errors++;
            return;
         end
         exp_r = expected_results.pop_front();
         if (got.status !== exp_r.status) begin
            $error("status: expected %0d, got %0d", exp_r.status, got.status);
            errors++;
         end
         if (got.adv_source !== exp_r.adv_source) begin
            $error("adv_source: expected %h, got %h", exp_r.adv_source, got.adv_source);
            errors++;
         end
         if (got.adv_dest !== exp_r.adv_dest) begin
            $error("adv_dest: expected %h, got %h", exp_r.adv_dest, got.adv_dest);
            errors++;
         end
         if (got.adv_sequence !== exp_r.adv_sequence) begin
            $error("adv_sequence: expected %h, got %h", exp_r.adv_sequence,
                   got.adv_sequence);
            errors++;
         end
         if (got.last !== exp_r.last) begin
            $error("last: expected %0b, got %0b", exp_r.last, got.last);
            errors++;
         end
      endfunction
   endclass

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_push = 1'b0;
   req_item_type req_data = '0;
   logic         full, req_full, empty, rsp_empty;
   logic         rsp_pop = 1'b0;
   rsp_item_type rsp_data;
   logic         csr_valid = 1'b0;
   logic         csr_ready;
   logic [7:0]   csr_index = '0;
   logic [63:0]  csr_wdata = '0;

   lsdb_scoreboard sb = new();
   int results_seen = 0;
   logic [63:0] addr_pool[4];

   link_state_database_aging_core #(.TABLE_DEPTH(DEPTH)) u_dut (
      .clock(clock), .reset(reset),
      .req_push(req_push), .req_data(req_data), .full(full), .req_full(req_full),
      .empty(empty), .rsp_empty(rsp_empty), .rsp_pop(rsp_pop), .rsp_data(rsp_data),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 94) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   function automatic logic [63:0] rand_word();
      int r;
      r = $urandom_range(0, 9);
      if (r == 0) return '0;
      if (r == 1) return '1;
      return {$urandom, $urandom};
   endfunction

   task automatic send_item(logic [1:0] m, logic [63:0] s, logic [63:0] d,
                            logic [63:0] q);
      req_item_type it;
      int gap;
      it.mode          = m;
      it.link_source   = s;
      it.link_dest     = d;
      it.link_sequence = q;
      req_data <= it;
      req_push <= 1'b1;
      do @(posedge clock); while (full);
      sb.note_request(it);
      gap = pick_gap();
      if (gap > 0) begin
         req_push <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // wait for every expected transaction, then let the table walk settle
   task automatic drain();
      req_push <= 1'b0;
      while (sb.expected_results.size() != 0) @(posedge clock);
      repeat (80) @(posedge clock);
   endtask

   task automatic write_csr(logic [7:0] idx, logic [63:0] value);
      csr_index <= idx;
      csr_wdata <= value;
      csr_valid <= 1'b1;
      do @(posedge clock); while (!csr_ready);
      sb.write_register(idx, value);
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic random_item(int fill_bias);
      int r;
      logic [1:0]  m;
      logic [63:0] s, d, q;
      r = $urandom_range(0, 99);
      if (r < 50 + fill_bias) m = MODE_ADVERT;
      else if (r < 65 + fill_bias) m = MODE_DELETE;
      else if (r < 82) m = MODE_TICK;
      else m = MODE_SWEEP;
      s = ($urandom_range(0, 1) == 0) ? sb.own_addr : addr_pool[$urandom_range(0, 3)];
      if ($urandom_range(0, 99) < 10 + fill_bias) s = rand_word();
      d = ($urandom_range(0, 99) < 15 + fill_bias) ? rand_word()
                                                 : {61'd0, 3'($urandom_range(0, 7))};
      q = ($urandom_range(0, 3) == 0) ? rand_word() : 64'($urandom_range(0, 20));
      send_item(m, s, d, q);
   endtask

   // result side: random stalls, one long hold-off so the input backs up
   initial begin
      int stall;
      bit held;
      stall = 0;
      held  = 0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_pop && !empty) begin
            sb.check_result(rsp_data);
            results_seen++;
         end
         if (stall > 0) begin
            stall--;
            rsp_pop <= 1'b0;
         end else if (!held && results_seen >= 120) begin
            held  = 1;
            stall = 400;
            rsp_pop <= 1'b0;
         end else if ((results_seen % 100) >= 30 && $urandom_range(0, 9) < 3) begin
            stall = pick_gap();
            rsp_pop <= 1'b0;
         end else begin
            rsp_pop <= 1'b1;
         end
      end
   end

   initial begin
      #(30_000_000);
      $display("testbench failed");
      $finish;
   end

   initial begin
      logic [63:0] own_settings[4];
      logic [15:0] age_settings[4];
      foreach (addr_pool[k]) addr_pool[k] = {$urandom, $urandom};
      addr_pool[0] = '1;
      own_settings = '{64'd0, '1, addr_pool[1], {$urandom, $urandom}};
      age_settings = '{16'd1, 16'hFFFF, 16'd0, 16'd3};
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: reset settings, own address zero
      send_item(MODE_ADVERT, 64'd0, 64'd5, 64'd0);
      send_item(MODE_ADVERT, 64'd0, 64'd5, 64'd0);          // equal seqno is stale
      send_item(MODE_ADVERT, 64'd0, 64'd5, 64'd7);          // refresh
      send_item(MODE_ADVERT, 64'd0, 64'd5, 64'd3);          // older seqno
      send_item(MODE_ADVERT, '1, '1, '1);
      send_item(MODE_ADVERT, 64'd9, 64'd2, 64'd1);          // lands ahead by dest
      send_item(MODE_ADVERT, 64'd1, 64'd2, 64'd1);          // same dest, lower source
      send_item(MODE_ADVERT, 64'd0, 64'd1, '1);             // own link, seqno wraps on sweep
      send_item(MODE_DELETE, 64'd4, 64'd4, 64'd0);          // unknown link
      send_item(MODE_DELETE, 64'd9, 64'd2, 64'd0);
      send_item(MODE_TICK, '0, '0, '0);
      send_item(MODE_SWEEP, '0, '0, '0);
      send_item(MODE_SWEEP, '0, '0, '0);
      send_item(MODE_ADVERT, 64'h5555_5555_5555_5555, 64'hAAAA_AAAA_AAAA_AAAA,
                64'h5555_5555_5555_5555);
      send_item(MODE_ADVERT, 64'hAAAA_AAAA_AAAA_AAAA, 64'h5555_5555_5555_5555,
                64'hAAAA_AAAA_AAAA_AAAA);
      drain();
      write_csr(8'd2, '1);                                  // unmapped index is ignored
      write_csr(CSR_LINK_TIMEOUT, 64'hFFFF_FFFF_FFFF_0000); // timeout zero
      send_item(MODE_TICK, '0, '0, '0);
      send_item(MODE_ADVERT, 64'd0, 64'd3, 64'd0);
      send_item(MODE_SWEEP, '0, '0, '0);                    // keeps only this second's links
      send_item(MODE_SWEEP, '0, '0, '0);
      drain();

      // fill the table to overflow, then random phases under each setting
      for (int k = 0; k < 36; k++)
         send_item(MODE_ADVERT, rand_word(), {58'd0, 6'(k)}, 64'($urandom_range(0, 9)));
      drain();
      foreach (own_settings[p]) begin
         write_csr(CSR_OWN_ADDRESS, own_settings[p]);
         write_csr(CSR_LINK_TIMEOUT, {48'd0, age_settings[p]});
         for (int k = 0; k < 95; k++) random_item(p == 1 ? 20 : 0);
         drain();
      end

      if (sb.expected_results.size() != 0) begin
         $error("%0d expected results never arrived", sb.expected_results.size());
         sb.errors++;
      end
      if (sb.errors == 0) $display("testbench passed");
      else $display("testbench failed");
      $finish;
   end

endmodule
